/* rtl/hmpd_pkg.sv */
package hmpd_pkg;

	localparam int PLANE_W   = 4;
	localparam int BITS_W    = 8;
	localparam int DATA_W    = 6;
	localparam int CTL_W     = 2;
	localparam int COMP_W    = 8;
	localparam int RGB_W     = 3 * COMP_W;
	localparam int PAL_DEPTH = 64;
	localparam int PAL_AW    = 6;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [PLANE_W-1:0] PLANE_COUNT_RESET = 4'd6;
	localparam logic [PLANE_W-1:0] HAM8_MIN_PLANES   = 4'd7;
	localparam logic [PLANE_W-1:0] MAX_PLANES        = 4'd8;

	// register index taken from paddr[2]
	localparam logic REG_PLANE_COUNT = 1'b0;

	localparam logic OP_PIXEL   = 1'b0;
	localparam logic OP_PALETTE = 1'b1;

	localparam logic [CTL_W-1:0] CTL_LOAD  = 2'd0;
	localparam logic [CTL_W-1:0] CTL_BLUE  = 2'd1;
	localparam logic [CTL_W-1:0] CTL_RED   = 2'd2;
	localparam logic [CTL_W-1:0] CTL_GREEN = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic              row_start;
		logic              wide;
		logic [CTL_W-1:0]  ctl;
		logic [DATA_W-1:0] data;
		logic [RGB_W-1:0]  pal_rgb;
	} pix_word_t;

endpackage

/* rtl/hmpd_ram.sv */
module hmpd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/hmpd_front.sv */
module hmpd_front import hmpd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [PLANE_W-1:0]  plane_count,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic [BITS_W-1:0]   pixel_bits,
	input  logic                row_start,
	input  logic [PAL_AW-1:0]   entry_index,
	input  logic [COMP_W-1:0]   entry_red,
	input  logic [COMP_W-1:0]   entry_green,
	input  logic [COMP_W-1:0]   entry_blue,
	output logic                q_push,
	output pix_word_t           q_word,
	input  logic                q_ready
);

	logic [PLANE_W-1:0] planes;
	logic [BITS_W-1:0]  masked;
	logic               wide;
	logic [DATA_W-1:0]  data;
	logic [CTL_W-1:0]   ctl;
	logic               accept;
	logic               pix_accept;
	logic               advance;
	logic [RGB_W-1:0]   rd_rgb;

	logic               valid_s1;
	logic               row_start_s1;
	logic               wide_s1;
	logic [CTL_W-1:0]   ctl_s1;
	logic [DATA_W-1:0]  data_s1;

	assign planes = (plane_count > MAX_PLANES) ? MAX_PLANES : plane_count;
	assign wide   = (plane_count >= HAM8_MIN_PLANES);

	// drop planes at or above the plane count
	always_comb begin
		for (int k = 0; k < BITS_W; k++) begin
			masked[k] = pixel_bits[k] & (PLANE_W'(k) < planes);
		end
	end

	always_comb begin
		if (wide) begin
			data = masked[5:0];
			ctl  = masked[7:6];
		end else begin
			data = {2'b00, masked[3:0]};
			ctl  = masked[5:4];
		end
	end

	assign advance    = valid_s1 & q_ready;
	assign in_ready   = ~valid_s1 | q_ready;
	assign accept     = in_valid & in_ready;
	assign pix_accept = accept & (opcode == OP_PIXEL);

	hmpd_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (accept & (opcode == OP_PALETTE)),
		.waddr (entry_index),
		.wdata ({entry_red, entry_green, entry_blue}),
		.re    (pix_accept),
		.raddr (data),
		.rdata (rd_rgb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			row_start_s1 <= row_start;
			wide_s1      <= wide;
			ctl_s1       <= ctl;
			data_s1      <= data;
		end
	end

	// read data stays put while the stage holds, since no read issues then
	assign q_push            = advance;
	assign q_word.row_start  = row_start_s1;
	assign q_word.wide       = wide_s1;
	assign q_word.ctl        = ctl_s1;
	assign q_word.data       = data_s1;
	assign q_word.pal_rgb    = rd_rgb;

endmodule

/* rtl/hmpd_queue.sv */
module hmpd_queue import hmpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pix_word_t push_word,
	output logic      push_ready,
	input  logic      pop,
	output pix_word_t pop_word,
	output logic      pop_valid
);

	pix_word_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q < QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push & push_ready;
	assign do_pop     = pop & pop_valid;
	assign pop_word   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

/* rtl/hmpd_back.sv */
module hmpd_back import hmpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  pix_word_t          q_word,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COMP_W-1:0]  red,
	output logic [COMP_W-1:0]  green,
	output logic [COMP_W-1:0]  blue
);

	logic [COMP_W-1:0] red_q, green_q, blue_q;
	logic              out_valid_q;
	logic [COMP_W-1:0] prior_r, prior_g, prior_b;
	logic [COMP_W-1:0] next_r, next_g, next_b;

	function automatic logic [COMP_W-1:0] modify(input logic [DATA_W-1:0] d,
	                                            input logic [COMP_W-1:0] old,
	                                            input logic wide);
		if (wide) begin
			return {d, old[1:0]};
		end
		return {d[3:0], d[3:0]};
	endfunction

	assign q_pop = q_valid & (~out_valid_q | out_ready);

	// row start clears the held color before this word applies
	assign prior_r = q_word.row_start ? '0 : red_q;
	assign prior_g = q_word.row_start ? '0 : green_q;
	assign prior_b = q_word.row_start ? '0 : blue_q;

	always_comb begin
		next_r = prior_r;
		next_g = prior_g;
		next_b = prior_b;
		unique case (q_word.ctl)
			CTL_LOAD: begin
				next_r = q_word.pal_rgb[3*COMP_W-1:2*COMP_W];
				next_g = q_word.pal_rgb[2*COMP_W-1:COMP_W];
				next_b = q_word.pal_rgb[COMP_W-1:0];
			end
			CTL_BLUE:  next_b = modify(q_word.data, prior_b, q_word.wide);
			CTL_RED:   next_r = modify(q_word.data, prior_r, q_word.wide);
			CTL_GREEN: next_g = modify(q_word.data, prior_g, q_word.wide);
			default: begin
				next_r = prior_r;
			end
		endcase
	end

	// held color doubles as the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
				red_q       <= next_r;
				green_q     <= next_g;
				blue_q      <= next_b;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

endmodule

/* rtl/hold_and_modify_pixel_decoder_unit.sv */
// channel  | handshake               | payload
// ---------+-------------------------+-----------------------------------------------
// in       | in_valid / in_ready     | opcode pixel_bits row_start entry_index
//          |                         | entry_red entry_green entry_blue
// out      | out_valid / out_ready   | red green blue
// config   | psel penable pwrite     | paddr pwdata prdata pready
//
// One word per clock in steady state while neither side stalls; a pixel passes
// the palette read at acceptance, then the queue, then the output register.
// The palette RAM read at acceptance forms the registered front stage; the queue holds
// two words so front and back stall independently.
// Reset clears control state, the held color (black) and plane_count (6);
// the palette is undefined until written. Palette writes produce no output.
module hold_and_modify_pixel_decoder_unit import hmpd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic [BITS_W-1:0]   pixel_bits,
	input  logic                row_start,
	input  logic [PAL_AW-1:0]   entry_index,
	input  logic [COMP_W-1:0]   entry_red,
	input  logic [COMP_W-1:0]   entry_green,
	input  logic [COMP_W-1:0]   entry_blue,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COMP_W-1:0]   red,
	output logic [COMP_W-1:0]   green,
	output logic [COMP_W-1:0]   blue
);

	logic [PLANE_W-1:0] plane_count_q;
	logic               q_push;
	logic               q_ready;
	logic               q_pop;
	logic               q_valid;
	pix_word_t          push_word;
	pix_word_t          pop_word;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= PLANE_COUNT_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_PLANE_COUNT)) begin
			plane_count_q <= pwdata[PLANE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_PLANE_COUNT) ?
	                {{(PDATA_W-PLANE_W){1'b0}}, plane_count_q} : '0;

	hmpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.plane_count (plane_count_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.pixel_bits  (pixel_bits),
		.row_start   (row_start),
		.entry_index (entry_index),
		.entry_red   (entry_red),
		.entry_green (entry_green),
		.entry_blue  (entry_blue),
		.q_push      (q_push),
		.q_word      (push_word),
		.q_ready     (q_ready)
	);

	hmpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_word  (push_word),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_word   (pop_word),
		.pop_valid  (q_valid)
	);

	hmpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_word    (pop_word),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

/* verif/ham_pixel_checker.sv */
`timescale 1ns / 1ps

module ham_pixel_checker import hmpd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                opcode,
	input  logic [BITS_W-1:0]   pixel_bits,
	input  logic                row_start,
	input  logic [PAL_AW-1:0]   entry_index,
	input  logic [COMP_W-1:0]   entry_red,
	input  logic [COMP_W-1:0]   entry_green,
	input  logic [COMP_W-1:0]   entry_blue,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [COMP_W-1:0]   red,
	input  logic [COMP_W-1:0]   green,
	input  logic [COMP_W-1:0]   blue,
	output int                  pending,
	output int                  fail_count
);

	// [2] red, [1] green, [0] blue
	typedef logic [2:0][COMP_W-1:0] rgb_t;

	rgb_t               palette [PAL_DEPTH];
	rgb_t               held;
	rgb_t               pixel_rgb_q [$];
	logic [PLANE_W-1:0] planes;
	int                 fails = 0;
	string              comp_name [3] = '{"blue", "green", "red"};

	function automatic logic [COMP_W-1:0] modified_comp(logic [DATA_W-1:0] data,
			logic [COMP_W-1:0] old, logic wide);
		// HAM8 keeps the two low bits, HAM6 replicates the nibble
		return wide ? {data, old[1:0]} : {data[3:0], data[3:0]};
	endfunction

	task automatic decode_pixel();
		logic [BITS_W:0]   mask;
		logic [BITS_W-1:0] bits;
		logic              wide;
		logic [DATA_W-1:0] data;
		logic [CTL_W-1:0]  ctl;
		mask = 9'd1 << ((planes > MAX_PLANES) ? MAX_PLANES : planes);
		mask = mask - 9'd1;
		bits = pixel_bits & mask[BITS_W-1:0];
		wide = planes >= HAM8_MIN_PLANES;
		data = wide ? bits[5:0] : {2'b00, bits[3:0]};
		ctl  = wide ? bits[7:6] : bits[5:4];
		if (row_start)
			held = '0;
		case (ctl)
			CTL_LOAD:  held    = palette[data];
			CTL_BLUE:  held[0] = modified_comp(data, held[0], wide);
			CTL_RED:   held[2] = modified_comp(data, held[2], wide);
			CTL_GREEN: held[1] = modified_comp(data, held[1], wide);
		endcase
		pixel_rgb_q.push_back(held);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rgb_t want;
		rgb_t got;
		if (!arst_n) begin
			held = '0;
			planes = PLANE_COUNT_RESET;
			pixel_rgb_q.delete();
			fails = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			// compare before pushing: a word leaving now can't be the one entering now
			if (out_valid && out_ready) begin
				got = {red, green, blue};
				if (pixel_rgb_q.size() == 0) begin
					$display("%0t: pixel word with none pending: expected none, got %h",
						$time, got);
					fails++;
				end else begin
					want = pixel_rgb_q.pop_front();
					for (int f = 0; f < 3; f++) begin
						if (got[f] !== want[f]) begin
							$display("%0t: %s mismatch: expected %h, got %h",
								$time, comp_name[f], want[f], got[f]);
							fails++;
						end
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr[2] == REG_PLANE_COUNT)
				planes = pwdata[PLANE_W-1:0];
			if (in_valid && in_ready) begin
				if (opcode == OP_PALETTE)
					palette[entry_index] = {entry_red, entry_green, entry_blue};
				else
					decode_pixel();
			end
			pending <= pixel_rgb_q.size();
			fail_count <= fails;
		end
	end

endmodule

/* verif/tb_hold_and_modify_pixel_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_hold_and_modify_pixel_decoder_unit;
	import hmpd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_WORDS = 1280;
	localparam int PHASES       = 9;
	localparam int HOLD_CYCLES  = 300;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               psel        = 1'b0;
	logic               penable     = 1'b0;
	logic               pwrite      = 1'b0;
	logic [PADDR_W-1:0] paddr       = '0;
	logic [PDATA_W-1:0] pwdata      = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic               opcode      = OP_PIXEL;
	logic [BITS_W-1:0]  pixel_bits  = '0;
	logic               row_start   = 1'b0;
	logic [PAL_AW-1:0]  entry_index = '0;
	logic [COMP_W-1:0]  entry_red   = '0;
	logic [COMP_W-1:0]  entry_green = '0;
	logic [COMP_W-1:0]  entry_blue  = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [COMP_W-1:0]  red;
	logic [COMP_W-1:0]  green;
	logic [COMP_W-1:0]  blue;

	int                 pending;
	int                 fail_count;
	int                 cycle_count   = 0;
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	int                 hold_left     = 0;
	logic               squeeze       = 1'b0;
	logic               squeezed      = 1'b0;
	logic [PLANE_W-1:0] planes        = PLANE_COUNT_RESET;
	bit                 written [PAL_DEPTH];
	int                 phase_planes [PHASES] = '{5, 7, 8, 15, 0, 6, 3, 7, 5};

	hold_and_modify_pixel_decoder_unit dut (.*);

	ham_pixel_checker pixel_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: one long hold-off when asked, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (squeeze && !squeezed) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			squeezed <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// palette entry a pixel would load under the current plane count, -1 on a modify
	function automatic int loaded_entry(logic [BITS_W-1:0] bits);
		logic [BITS_W:0]   mask;
		logic [BITS_W-1:0] b;
		mask = 9'd1 << ((planes > MAX_PLANES) ? MAX_PLANES : planes);
		mask = mask - 9'd1;
		b = bits & mask[BITS_W-1:0];
		if (planes >= HAM8_MIN_PLANES)
			return (b[7:6] == CTL_LOAD) ? int'(b[5:0]) : -1;
		return (b[5:4] == CTL_LOAD) ? int'(b[3:0]) : -1;
	endfunction

	task automatic send_word(logic op, logic [BITS_W-1:0] bits, logic rs,
			logic [PAL_AW-1:0] idx, logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
			logic [COMP_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		pixel_bits <= bits;
		row_start <= rs;
		entry_index <= idx;
		entry_red <= r;
		entry_green <= g;
		entry_blue <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_entry(logic [PAL_AW-1:0] idx, logic [COMP_W-1:0] r,
			logic [COMP_W-1:0] g, logic [COMP_W-1:0] b);
		send_word(OP_PALETTE, BITS_W'($urandom()), 1'($urandom()), idx, r, g, b);
		written[idx] = 1'b1;
	endtask

	task automatic send_pixel(logic [BITS_W-1:0] bits, logic rs);
		int e;
		e = loaded_entry(bits);
		// never load an entry that was never written: fill it first
		if (e >= 0 && !written[e])
			write_entry(PAL_AW'(e), COMP_W'($urandom_range(255)),
				COMP_W'($urandom_range(255)), COMP_W'($urandom_range(255)));
		send_word(OP_PIXEL, bits, rs, PAL_AW'($urandom()), COMP_W'($urandom()),
			COMP_W'($urandom()), COMP_W'($urandom()));
	endtask

	// drop valid, drain the pipe, then let in-flight palette words settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_planes(int value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_PLANE_COUNT, 2'b00};
		pwdata <= {(PDATA_W-PLANE_W)'($urandom()), PLANE_W'(value)};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		planes = PLANE_W'(value);
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin
				send_idle_pct = 20;
				recv_idle_pct <= 49;
			end
			1: begin
				send_idle_pct = 49;
				recv_idle_pct <= 20;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
		endcase
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(0);

		// HAM6 at the reset plane count
		write_entry(6'd0, 8'h12, 8'h34, 8'h56);
		write_entry(6'd63, 8'hff, 8'hff, 8'hff);
		write_entry(6'd15, 8'h00, 8'h00, 8'h00);
		write_entry(6'd5, 8'ha5, 8'h5a, 8'hc3);
		send_pixel(8'h00, 1'b1);
		send_pixel(8'h1f, 1'b0);
		send_pixel(8'h20, 1'b0);
		send_pixel(8'h3a, 1'b0);
		send_pixel(8'h0f, 1'b0);
		// upper planes ignored, row start clears to black before the modify
		send_pixel(8'hf5, 1'b1);
		send_pixel(8'hff, 1'b0);
		// rewrite an entry and load it right behind the write
		write_entry(6'd5, 8'h80, 8'h01, 8'h7f);
		send_pixel(8'h05, 1'b1);

		// HAM8
		set_planes(8);
		send_pixel(8'h3f, 1'b0);
		send_pixel(8'h7f, 1'b0);
		send_pixel(8'h80, 1'b0);
		send_pixel(8'hc0, 1'b1);
		send_pixel(8'hff, 1'b0);

		// missing upper control bit
		set_planes(5);
		send_pixel(8'hff, 1'b0);
		set_planes(7);
		send_pixel(8'hff, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			set_planes(phase_planes[p]);
			set_idling(p / 3);
			if (p == 6)
				squeeze <= 1'b1;
			for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
				if ($urandom_range(99) < 15)
					write_entry(PAL_AW'($urandom_range(63)), COMP_W'($urandom_range(255)),
						COMP_W'($urandom_range(255)), COMP_W'($urandom_range(255)));
				else
					send_pixel(BITS_W'($urandom_range(255)), $urandom_range(99) < 10);
			end
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
